/* hdl/css_pkg.sv */
`timescale 1ns / 1ps

package css_pkg;

   localparam int TIME_W    = 17;
   localparam int DATE_W    = 21;
   localparam int TOL_W     = 17;
   localparam int HOLD_W    = 32;
   localparam int TMO_W     = 16;
   localparam int STAMP_W   = 32;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;

   localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(1);
   localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(43200);
   localparam logic [TMO_W-1:0]  TMO_RESET  = TMO_W'(1);

   // sync flag bit positions
   localparam int F_RADIO = 0;
   localparam int F_RTC   = 1;
   localparam int F_INT   = 2;
   localparam int F_FINAL = 3;

   typedef enum logic [1:0] {
      SRC_NONE  = 2'd0,
      SRC_RADIO = 2'd1,
      SRC_RTC   = 2'd2,
      SRC_INT   = 2'd3
   } src_type;

   typedef enum logic [1:0] {
      CSR_TOLERANCE = 2'd0,
      CSR_HOLDOVER  = 2'd1,
      CSR_TIMEOUT   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [TOL_W-1:0]  sync_tolerance_s;
      logic [HOLD_W-1:0] radio_holdover_s;
      logic [TMO_W-1:0]  source_timeout_s;
   } cfg_type;

   typedef struct packed {
      logic              radio_new;
      logic [TIME_W-1:0] radio_time;
      logic [DATE_W-1:0] radio_date;
      logic              rtc_new;
      logic [TIME_W-1:0] rtc_time;
      logic [DATE_W-1:0] rtc_date;
      logic              internal_new;
      logic [TIME_W-1:0] internal_time;
      logic [DATE_W-1:0] internal_date;
      logic              second_tick;
      logic              rtc_write_done;
      logic              internal_write_ok;
   } req_item_type;

   typedef struct packed {
      logic [TIME_W-1:0] final_time;
      logic [DATE_W-1:0] final_date;
      logic              final_synced;
      src_type           final_source;
      logic              rtc_write_req;
      logic              internal_write_req;
      logic              radio_synced;
      logic              rtc_synced;
      logic              internal_synced;
   } rsp_item_type;

   // |a_time - b_time| beyond tolerance, or a different date
   function automatic logic differs(input logic [TIME_W-1:0] at,
                                    input logic [DATE_W-1:0] ad,
                                    input logic [TIME_W-1:0] bt,
                                    input logic [DATE_W-1:0] bd,
                                    input logic [TOL_W-1:0]  tol);
      logic [TIME_W-1:0] mag;
      mag = (at >= bt) ? (at - bt) : (bt - at);
      return (mag > tol) || (ad != bd);
   endfunction

   function automatic logic expired(input logic [STAMP_W-1:0] now,
                                    input logic [STAMP_W-1:0] stamp,
                                    input logic [STAMP_W-1:0] limit);
      logic [STAMP_W-1:0] age;
      age = now - stamp;
      return age > limit;
   endfunction

endpackage

/* hdl/css_core.sv */
`timescale 1ns / 1ps

module css_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  css_pkg::req_item_type item,
   input  css_pkg::cfg_type      cfg,
   output css_pkg::rsp_item_type result
);
   import css_pkg::*;

   logic [STAMP_W-1:0] sec_ff, sec_in;
   logic [STAMP_W-1:0] radio_stamp_ff, radio_stamp_in;
   logic [STAMP_W-1:0] rtc_stamp_ff, rtc_stamp_in;
   logic [STAMP_W-1:0] int_stamp_ff, int_stamp_in;
   logic [STAMP_W-1:0] fin_stamp_ff, fin_stamp_in;
   logic [3:0]         flags_ff, flags_in;
   logic [TIME_W-1:0]  rtc_time_ff, rtc_time_in;
   logic [DATE_W-1:0]  rtc_date_ff, rtc_date_in;
   logic [TIME_W-1:0]  int_time_ff, int_time_in;
   logic [DATE_W-1:0]  int_date_ff, int_date_in;
   logic [TIME_W-1:0]  ch_time_ff, ch_time_in;
   logic [DATE_W-1:0]  ch_date_ff, ch_date_in;
   src_type            ch_src_ff, ch_src_in;
   logic               fin_set;
   logic               rtc_req;
   logic               int_req;

   always_comb begin
      flags_in       = flags_ff;
      sec_in         = sec_ff;
      radio_stamp_in = radio_stamp_ff;
      rtc_stamp_in   = rtc_stamp_ff;
      int_stamp_in   = int_stamp_ff;
      fin_stamp_in   = fin_stamp_ff;
      rtc_time_in    = rtc_time_ff;
      rtc_date_in    = rtc_date_ff;
      int_time_in    = int_time_ff;
      int_date_in    = int_date_ff;
      ch_time_in     = ch_time_ff;
      ch_date_in     = ch_date_ff;
      ch_src_in      = ch_src_ff;
      fin_set        = 1'b0;
      rtc_req        = 1'b0;
      int_req        = 1'b0;

      if (item.rtc_write_done) flags_in[F_RTC] = 1'b1;
      if (item.second_tick) sec_in = sec_ff + STAMP_W'(1);

      // stamp fresh readings; store the RTC and internal ones
      if (item.radio_new) radio_stamp_in = sec_in;
      if (item.rtc_new) begin
         rtc_time_in  = item.rtc_time;
         rtc_date_in  = item.rtc_date;
         rtc_stamp_in = sec_in;
      end
      if (item.internal_new) begin
         int_time_in  = item.internal_time;
         int_date_in  = item.internal_date;
         int_stamp_in = sec_in;
      end

      // radio first
      if (item.radio_new) begin
         ch_time_in   = item.radio_time;
         ch_date_in   = item.radio_date;
         ch_src_in    = SRC_RADIO;
         fin_stamp_in = sec_in;
         fin_set      = 1'b1;
         if (differs(item.radio_time, item.radio_date, rtc_time_in, rtc_date_in,
                     cfg.sync_tolerance_s)) begin
            rtc_req         = 1'b1;
            flags_in[F_RTC] = 1'b0;
         end
         flags_in[F_RADIO] = 1'b1;
      end

      // battery RTC
      if (item.rtc_new) begin
         if (!flags_in[F_RTC]) begin
            if (!flags_in[F_RADIO]) flags_in[F_RTC] = 1'b1;
         end else if (!fin_set) begin
            ch_time_in   = rtc_time_in;
            ch_date_in   = rtc_date_in;
            ch_src_in    = SRC_RTC;
            fin_stamp_in = sec_in;
            fin_set      = 1'b1;
         end
      end

      // internal clock resync from a valid external final time
      if (item.internal_new && (flags_in[F_FINAL] || fin_set) && ch_src_in != SRC_INT) begin
         if (differs(int_time_in, int_date_in, ch_time_in, ch_date_in,
                     cfg.sync_tolerance_s)) begin
            int_req         = 1'b1;
            flags_in[F_INT] = item.internal_write_ok;
         end
      end

      if (fin_set) flags_in[F_FINAL] = 1'b1;

      // timeouts on the tick, then holdover on the internal clock
      if (item.second_tick) begin
         if (flags_in[F_RADIO] && expired(sec_in, radio_stamp_in, cfg.radio_holdover_s))
            flags_in[F_RADIO] = 1'b0;
         if (flags_in[F_RTC] && expired(sec_in, rtc_stamp_in,
                                        STAMP_W'(cfg.source_timeout_s)))
            flags_in[F_RTC] = 1'b0;
         if (flags_in[F_INT] && expired(sec_in, int_stamp_in,
                                        STAMP_W'(cfg.source_timeout_s)))
            flags_in[F_INT] = 1'b0;
         if (flags_in[F_FINAL] && expired(sec_in, fin_stamp_in,
                                          STAMP_W'(cfg.source_timeout_s)))
            flags_in[F_FINAL] = 1'b0;
         if (!flags_in[F_FINAL]) begin
            ch_time_in   = int_time_in;
            ch_date_in   = int_date_in;
            ch_src_in    = SRC_INT;
            fin_stamp_in = sec_in;
            if (flags_in[F_INT]) flags_in[F_FINAL] = 1'b1;
         end
      end

      result.final_time         = ch_time_in;
      result.final_date         = ch_date_in;
      result.final_synced       = flags_in[F_FINAL];
      result.final_source       = ch_src_in;
      result.rtc_write_req      = rtc_req;
      result.internal_write_req = int_req;
      result.radio_synced       = flags_in[F_RADIO];
      result.rtc_synced         = flags_in[F_RTC];
      result.internal_synced    = flags_in[F_INT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff         <= '0;
         radio_stamp_ff <= '0;
         rtc_stamp_ff   <= '0;
         int_stamp_ff   <= '0;
         fin_stamp_ff   <= '0;
         flags_ff       <= '0;
         rtc_time_ff    <= '0;
         rtc_date_ff    <= '0;
         int_time_ff    <= '0;
         int_date_ff    <= '0;
         ch_time_ff     <= '0;
         ch_date_ff     <= '0;
         ch_src_ff      <= SRC_NONE;
      end else if (step) begin
         sec_ff         <= sec_in;
         radio_stamp_ff <= radio_stamp_in;
         rtc_stamp_ff   <= rtc_stamp_in;
         int_stamp_ff   <= int_stamp_in;
         fin_stamp_ff   <= fin_stamp_in;
         flags_ff       <= flags_in;
         rtc_time_ff    <= rtc_time_in;
         rtc_date_ff    <= rtc_date_in;
         int_time_ff    <= int_time_in;
         int_date_ff    <= int_date_in;
         ch_time_ff     <= ch_time_in;
         ch_date_ff     <= ch_date_in;
         ch_src_ff      <= ch_src_in;
      end
   end

endmodule

/* hdl/clock_source_selector_unit.sv */
`timescale 1ns / 1ps
// Clock source selector.
// One req item is one poll cycle: fresh radio, battery RTC and internal clock
// readings (each with its _new bit), the one-second tick and the outcomes of
// earlier clock writes. One rsp item comes back for every req item, in order:
// the chosen time and date, its source and sync state, the RTC / internal
// write requests and the per-source sync flags after that poll.
// Handshake: an item moves on a rising edge with valid high and stall low.
// Path: the input register, then one pass of selection logic into the result
// register, which drives rsp. Throughput: one item per cycle while rsp is
// not stalled, set by the single-pass selection between the two registers;
// the seconds count and stamps update as the item passes.
// Receiver stall: the result register holds; the input register still takes
// one more item, then req_stall rises until the result is taken.
// Reset (synchronous, active high): both registers empty, all stamps, readings
// and sync flags cleared, source none, registers back to their defaults.
// CSR (APB-style, pready tied high): 0x0 sync tolerance, 0x4 radio holdover,
// 0x8 source timeout. Write only while no item is in flight.

module clock_source_selector_unit (
   input  logic                        clock,
   input  logic                        reset,
   // poll items
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_radio_new,
   input  logic [css_pkg::TIME_W-1:0]  req_radio_time,
   input  logic [css_pkg::DATE_W-1:0]  req_radio_date,
   input  logic                        req_rtc_new,
   input  logic [css_pkg::TIME_W-1:0]  req_rtc_time,
   input  logic [css_pkg::DATE_W-1:0]  req_rtc_date,
   input  logic                        req_internal_new,
   input  logic [css_pkg::TIME_W-1:0]  req_internal_time,
   input  logic [css_pkg::DATE_W-1:0]  req_internal_date,
   input  logic                        req_second_tick,
   input  logic                        req_rtc_write_done,
   input  logic                        req_internal_write_ok,
   // results
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [css_pkg::TIME_W-1:0]  rsp_final_time,
   output logic [css_pkg::DATE_W-1:0]  rsp_final_date,
   output logic                        rsp_final_synced,
   output logic [1:0]                  rsp_final_source,
   output logic                        rsp_rtc_write_req,
   output logic                        rsp_internal_write_req,
   output logic                        rsp_radio_synced,
   output logic                        rsp_rtc_synced,
   output logic                        rsp_internal_synced,
   // configuration
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [css_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [css_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [css_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import css_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type core_result;
   logic         req_take;
   logic         move;
   logic         csr_write;

   // ---- CSR ----
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            CSR_TOLERANCE: cfg_in.sync_tolerance_s = csr_pwdata[TOL_W-1:0];
            CSR_HOLDOVER:  cfg_in.radio_holdover_s = csr_pwdata[HOLD_W-1:0];
            CSR_TIMEOUT:   cfg_in.source_timeout_s = csr_pwdata[TMO_W-1:0];
            default:       cfg_in = cfg_ff;   // unmapped: dropped
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         CSR_TOLERANCE: csr_prdata = CSR_DW'(cfg_ff.sync_tolerance_s);
         CSR_HOLDOVER:  csr_prdata = CSR_DW'(cfg_ff.radio_holdover_s);
         CSR_TIMEOUT:   csr_prdata = CSR_DW'(cfg_ff.source_timeout_s);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_tolerance_s <= TOL_RESET;
         cfg_ff.radio_holdover_s <= HOLD_RESET;
         cfg_ff.source_timeout_s <= TMO_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- two-register pipe ----
   // move: the held item passes through the selector into the result register
   assign move      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !move;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)  in_valid_in = 1'b1;
      else if (move) in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (move)            out_valid_in = 1'b1;
      else if (!rsp_stall) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.radio_new         <= req_radio_new;
         in_item_ff.radio_time        <= req_radio_time;
         in_item_ff.radio_date        <= req_radio_date;
         in_item_ff.rtc_new           <= req_rtc_new;
         in_item_ff.rtc_time          <= req_rtc_time;
         in_item_ff.rtc_date          <= req_rtc_date;
         in_item_ff.internal_new      <= req_internal_new;
         in_item_ff.internal_time     <= req_internal_time;
         in_item_ff.internal_date     <= req_internal_date;
         in_item_ff.second_tick       <= req_second_tick;
         in_item_ff.rtc_write_done    <= req_rtc_write_done;
         in_item_ff.internal_write_ok <= req_internal_write_ok;
      end
      if (move) out_item_ff <= core_result;
   end

   // selector and its state; state advances only when an item passes
   css_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (move),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   assign rsp_valid              = out_valid_ff;
   assign rsp_final_time         = out_item_ff.final_time;
   assign rsp_final_date         = out_item_ff.final_date;
   assign rsp_final_synced       = out_item_ff.final_synced;
   assign rsp_final_source       = out_item_ff.final_source;
   assign rsp_rtc_write_req      = out_item_ff.rtc_write_req;
   assign rsp_internal_write_req = out_item_ff.internal_write_req;
   assign rsp_radio_synced       = out_item_ff.radio_synced;
   assign rsp_rtc_synced         = out_item_ff.rtc_synced;
   assign rsp_internal_synced    = out_item_ff.internal_synced;

endmodule

/* hdl/css_checker.sv */
`timescale 1ns / 1ps

module css_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_final_source,
   input logic       rsp_final_synced,
   input logic       rsp_rtc_write_req,
   input logic       rsp_radio_synced,
   input logic       rsp_rtc_synced
);
   import css_pkg::*;

   // a stalled result stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp item dropped under stall");

   // an RTC rewrite comes only from a fresh radio time, which wins the choice
   a_rtc_req_radio: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rtc_write_req |->
         rsp_radio_synced && rsp_final_synced && !rsp_rtc_synced &&
         rsp_final_source == SRC_RADIO)
      else $error("RTC write request without a leading radio time");

   // no time ever chosen means final cannot be in sync
   a_none_unsynced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_source == SRC_NONE |-> !rsp_final_synced)
      else $error("final in sync with no source");

   // pipe comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid straight after reset");

endmodule

bind clock_source_selector_unit css_checker u_css_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_final_source (rsp_final_source),
   .rsp_final_synced (rsp_final_synced),
   .rsp_rtc_write_req(rsp_rtc_write_req),
   .rsp_radio_synced (rsp_radio_synced),
   .rsp_rtc_synced   (rsp_rtc_synced)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import css_pkg::*;

   localparam int TIME_MAX    = 86399;
   localparam int DATE_MAX    = (1 << DATE_W) - 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 8;
   localparam int PHASE_POLLS = 75;

   // ---------------------------------------------------------------------
   // DUT ports
   // ---------------------------------------------------------------------
   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_radio_new;
   logic [TIME_W-1:0] req_radio_time;
   logic [DATE_W-1:0] req_radio_date;
   logic              req_rtc_new;
   logic [TIME_W-1:0] req_rtc_time;
   logic [DATE_W-1:0] req_rtc_date;
   logic              req_internal_new;
   logic [TIME_W-1:0] req_internal_time;
   logic [DATE_W-1:0] req_internal_date;
   logic              req_second_tick;
   logic              req_rtc_write_done;
   logic              req_internal_write_ok;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [TIME_W-1:0] rsp_final_time;
   logic [DATE_W-1:0] rsp_final_date;
   logic              rsp_final_synced;
   logic [1:0]        rsp_final_source;
   logic              rsp_rtc_write_req;
   logic              rsp_internal_write_req;
   logic              rsp_radio_synced;
   logic              rsp_rtc_synced;
   logic              rsp_internal_synced;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   clock_source_selector_unit uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_radio_new          (req_radio_new),
      .req_radio_time         (req_radio_time),
      .req_radio_date         (req_radio_date),
      .req_rtc_new            (req_rtc_new),
      .req_rtc_time           (req_rtc_time),
      .req_rtc_date           (req_rtc_date),
      .req_internal_new       (req_internal_new),
      .req_internal_time      (req_internal_time),
      .req_internal_date      (req_internal_date),
      .req_second_tick        (req_second_tick),
      .req_rtc_write_done     (req_rtc_write_done),
      .req_internal_write_ok  (req_internal_write_ok),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_final_time         (rsp_final_time),
      .rsp_final_date         (rsp_final_date),
      .rsp_final_synced       (rsp_final_synced),
      .rsp_final_source       (rsp_final_source),
      .rsp_rtc_write_req      (rsp_rtc_write_req),
      .rsp_internal_write_req (rsp_internal_write_req),
      .rsp_radio_synced       (rsp_radio_synced),
      .rsp_rtc_synced         (rsp_rtc_synced),
      .rsp_internal_synced    (rsp_internal_synced),
      .csr_psel               (csr_psel),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_paddr              (csr_paddr),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata),
      .csr_pready             (csr_pready)
   );

   // 12 ns period
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow of the selector: configuration, seconds count, stamps, flags
   // and last readings, all advanced once per accepted poll item.
   // ---------------------------------------------------------------------
   logic [TOL_W-1:0]   tol_cfg   = TOL_RESET;
   logic [HOLD_W-1:0]  hold_cfg  = HOLD_RESET;
   logic [TMO_W-1:0]   tmo_cfg   = TMO_RESET;

   logic [STAMP_W-1:0] now_s     = '0;
   logic [STAMP_W-1:0] radio_at  = '0;
   logic [STAMP_W-1:0] rtc_at    = '0;
   logic [STAMP_W-1:0] int_at    = '0;
   logic [STAMP_W-1:0] chosen_at = '0;
   logic [3:0]         flags     = '0;   // indexed by F_RADIO .. F_FINAL
   logic [TIME_W-1:0]  rtc_t     = '0;
   logic [DATE_W-1:0]  rtc_d     = '0;
   logic [TIME_W-1:0]  int_t     = '0;
   logic [DATE_W-1:0]  int_d     = '0;
   logic [TIME_W-1:0]  pick_t    = '0;
   logic [DATE_W-1:0]  pick_d    = '0;
   src_type            pick_src  = SRC_NONE;

   // Plain signed difference, no wrap at midnight; any date change counts.
   function automatic logic beyond_tol(input logic [TIME_W-1:0] at,
                                       input logic [DATE_W-1:0] ad,
                                       input logic [TIME_W-1:0] bt,
                                       input logic [DATE_W-1:0] bd);
      int d;
      int t;
      d = int'(at) - int'(bt);
      t = int'(tol_cfg);
      return (d > t) || (d < -t) || (ad != bd);
   endfunction

   // age modulo 2^32, strictly greater than the limit
   function automatic logic stale(input logic [STAMP_W-1:0] stamp,
                                  input logic [STAMP_W-1:0] limit);
      logic [STAMP_W-1:0] age;
      age = now_s - stamp;
      return age > limit;
   endfunction

   function automatic void take_final(input logic [TIME_W-1:0] t,
                                      input logic [DATE_W-1:0] d,
                                      input src_type src);
      pick_t    = t;
      pick_d    = d;
      pick_src  = src;
      chosen_at = now_s;
   endfunction

   // One poll cycle of the selector, in the block's own order: write-done
   // callback, tick, stamping, selection, then timeouts on a tick.
   function automatic rsp_item_type poll_step(input req_item_type p);
      rsp_item_type r;
      logic fin_set;
      logic want_rtc;
      logic want_int;
      fin_set  = 1'b0;
      want_rtc = 1'b0;
      want_int = 1'b0;

      if (p.rtc_write_done) flags[F_RTC] = 1'b1;
      if (p.second_tick) now_s = now_s + 1;

      if (p.radio_new) radio_at = now_s;
      if (p.rtc_new) begin
         rtc_t  = p.rtc_time;
         rtc_d  = p.rtc_date;
         rtc_at = now_s;
      end
      if (p.internal_new) begin
         int_t  = p.internal_time;
         int_d  = p.internal_date;
         int_at = now_s;
      end

      // radio wins outright and may force an RTC rewrite
      if (p.radio_new) begin
         take_final(p.radio_time, p.radio_date, SRC_RADIO);
         fin_set = 1'b1;
         if (beyond_tol(p.radio_time, p.radio_date, rtc_t, rtc_d)) begin
            want_rtc     = 1'b1;
            flags[F_RTC] = 1'b0;
         end
         flags[F_RADIO] = 1'b1;
      end

      // an unsynced RTC only trusts itself when radio is absent
      if (p.rtc_new) begin
         if (!flags[F_RTC]) begin
            if (!flags[F_RADIO]) flags[F_RTC] = 1'b1;
         end else if (!fin_set) begin
            take_final(rtc_t, rtc_d, SRC_RTC);
            fin_set = 1'b1;
         end
      end

      // internal clock follows a valid final time from another source
      if (p.internal_new && (flags[F_FINAL] || fin_set) && pick_src != SRC_INT &&
          beyond_tol(int_t, int_d, pick_t, pick_d)) begin
         want_int     = 1'b1;
         flags[F_INT] = p.internal_write_ok;
      end

      if (fin_set) flags[F_FINAL] = 1'b1;

      if (p.second_tick) begin
         if (flags[F_RADIO] && stale(radio_at, hold_cfg)) flags[F_RADIO] = 1'b0;
         if (flags[F_RTC] && stale(rtc_at, STAMP_W'(tmo_cfg))) flags[F_RTC] = 1'b0;
         if (flags[F_INT] && stale(int_at, STAMP_W'(tmo_cfg))) flags[F_INT] = 1'b0;
         if (flags[F_FINAL] && stale(chosen_at, STAMP_W'(tmo_cfg))) flags[F_FINAL] = 1'b0;
         // holdover on the stored internal value
         if (!flags[F_FINAL]) begin
            take_final(int_t, int_d, SRC_INT);
            if (flags[F_INT]) flags[F_FINAL] = 1'b1;
         end
      end

      r.final_time         = pick_t;
      r.final_date         = pick_d;
      r.final_synced       = flags[F_FINAL];
      r.final_source       = pick_src;
      r.rtc_write_req      = want_rtc;
      r.internal_write_req = want_int;
      r.radio_synced       = flags[F_RADIO];
      r.rtc_synced         = flags[F_RTC];
      r.internal_synced    = flags[F_INT];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Bookkeeping shared by the processes below
   // ---------------------------------------------------------------------
   req_item_type pending_polls[$];   // filled by the sequence, drained by the driver
   rsp_item_type expected_sel[$];    // predicted results, oldest first
   int  errors        = 0;
   int  polls_queued  = 0;
   int  polls_taken   = 0;
   int  results_seen  = 0;
   int  settings_used = 1;
   int  rtc_req_seen  = 0;
   int  int_req_seen  = 0;
   int  src_seen[4]   = '{0, 0, 0, 0};
   bit  req_taken     = 1'b0;
   int  cycle_count   = 0;

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: bursts of items with random gaps. A presented item is held
   // until taken; the gap decision never looks at req_stall.
   // ---------------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(negedge clock) begin
      req_item_type p;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // stalled: payload and valid stay put
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (pending_polls.size() > 0) begin
         p = pending_polls.pop_front();
         req_radio_new         <= p.radio_new;
         req_radio_time        <= p.radio_time;
         req_radio_date        <= p.radio_date;
         req_rtc_new           <= p.rtc_new;
         req_rtc_time          <= p.rtc_time;
         req_rtc_date          <= p.rtc_date;
         req_internal_new      <= p.internal_new;
         req_internal_time     <= p.internal_time;
         req_internal_date     <= p.internal_date;
         req_second_tick       <= p.second_tick;
         req_rtc_write_done    <= p.rtc_write_done;
         req_internal_write_ok <= p.internal_write_ok;
         req_valid             <= 1'b1;
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            // a quarter of bursts run straight into the next one
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Receiver stall: changing patterns, plus one long hold-off while the
   // sender still has plenty queued, so the block backs up to its input.
   // ---------------------------------------------------------------------
   int  stall_mode = 0;
   int  mode_left  = 0;
   int  hold_left  = 0;
   bit  hold_done  = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && polls_taken > 150 && pending_polls.size() > 20) begin
         hold_done = 1'b1;
         hold_left = 59;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left <= 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(10, 60);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;                            // free running
            1: rsp_stall <= ($urandom_range(0, 3) == 0);     // light
            2: rsp_stall <= ($urandom_range(0, 3) != 0);     // heavy
            default: rsp_stall <= ~rsp_stall;                // alternating
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: on each rising edge, predict for an item taken on req and
   // check a result taken on rsp against the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      req_item_type seen;
      rsp_item_type want;
      rsp_item_type got;
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         seen = {req_radio_new, req_radio_time, req_radio_date,
                 req_rtc_new, req_rtc_time, req_rtc_date,
                 req_internal_new, req_internal_time, req_internal_date,
                 req_second_tick, req_rtc_write_done, req_internal_write_ok};
         expected_sel.push_back(poll_step(seen));
         polls_taken++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_final_time, rsp_final_date, rsp_final_synced, rsp_final_source,
                rsp_rtc_write_req, rsp_internal_write_req,
                rsp_radio_synced, rsp_rtc_synced, rsp_internal_synced};
         results_seen++;
         if (expected_sel.size() == 0) begin
            $display("%0t ns: result with nothing expected, final_time %0d", $time,
                     got.final_time);
            errors++;
         end else begin
            want = expected_sel.pop_front();
            check_field("final_time", 32'(want.final_time), 32'(got.final_time));
            check_field("final_date", 32'(want.final_date), 32'(got.final_date));
            check_field("final_synced", 32'(want.final_synced), 32'(got.final_synced));
            check_field("final_source", 32'(want.final_source), 32'(got.final_source));
            check_field("rtc_write_req", 32'(want.rtc_write_req),
                        32'(got.rtc_write_req));
            check_field("internal_write_req", 32'(want.internal_write_req),
                        32'(got.internal_write_req));
            check_field("radio_synced", 32'(want.radio_synced), 32'(got.radio_synced));
            check_field("rtc_synced", 32'(want.rtc_synced), 32'(got.rtc_synced));
            check_field("internal_synced", 32'(want.internal_synced),
                        32'(got.internal_synced));
         end
         if (got.rtc_write_req) rtc_req_seen++;
         if (got.internal_write_req) int_req_seen++;
         src_seen[got.final_source]++;
      end
   end

   // Watchdog: sized well beyond the slowest legal run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
               polls_queued - results_seen);
      $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   int                world_t = 0;    // the "true" time the sources roughly agree on
   logic [DATE_W-1:0] world_d = '0;

   function automatic req_item_type poll(input bit rn, input int rt, input int rd,
                                         input bit cn, input int ct, input int cd,
                                         input bit in_, input int it, input int id,
                                         input bit tick, input bit done, input bit ok);
      req_item_type p;
      p = {rn, TIME_W'(rt), DATE_W'(rd), cn, TIME_W'(ct), DATE_W'(cd),
           in_, TIME_W'(it), DATE_W'(id), tick, done, ok};
      return p;
   endfunction

   function automatic logic [TIME_W-1:0] any_time();
      return TIME_W'($urandom_range(0, TIME_MAX));
   endfunction

   function automatic logic [DATE_W-1:0] any_date();
      return DATE_W'($urandom);
   endfunction

   // a reading scattered around base, kept inside the day
   function automatic logic [TIME_W-1:0] near_time(input int base, input int spread);
      int v;
      v = base - spread + int'($urandom_range(0, 2 * spread));
      if (v < 0) v = 0;
      else if (v > TIME_MAX) v = TIME_MAX;
      return TIME_W'(v);
   endfunction

   // Mostly coherent polls: a ticking world clock with sources near it,
   // readings just inside or outside tolerance, the odd wrong date.
   // One in five is pure noise across every field.
   function automatic req_item_type make_poll();
      req_item_type p;
      int spread;
      p = '0;
      spread = (tol_cfg > 100) ? 102 : int'(tol_cfg) + 2;
      if ($urandom_range(0, 4) == 0) begin
         p = {1'($urandom), any_time(), any_date(), 1'($urandom), any_time(), any_date(),
              1'($urandom), any_time(), any_date(), 1'($urandom), 1'($urandom),
              1'($urandom)};
      end else begin
         p.second_tick = ($urandom_range(0, 99) < 45);
         if (p.second_tick) begin
            if (world_t == TIME_MAX) begin
               world_t = 0;
               world_d = world_d + DATE_W'(1);
            end else begin
               world_t++;
            end
         end
         p.radio_new         = ($urandom_range(0, 99) < 12);
         p.radio_time        = near_time(world_t, spread);
         p.radio_date        = ($urandom_range(0, 9) == 0) ? any_date() : world_d;
         p.rtc_new           = ($urandom_range(0, 99) < 30);
         p.rtc_time          = near_time(world_t, spread);
         p.rtc_date          = ($urandom_range(0, 9) == 0) ? any_date() : world_d;
         p.internal_new      = ($urandom_range(0, 99) < 30);
         p.internal_time     = near_time(world_t, ($urandom_range(0, 3) == 0) ?
                                                   4 * spread : spread);
         p.internal_date     = ($urandom_range(0, 9) == 0) ? any_date() : world_d;
         p.rtc_write_done    = ($urandom_range(0, 99) < 20);
         p.internal_write_ok = 1'($urandom);
      end
      return p;
   endfunction

   task automatic add_poll(input req_item_type p);
      pending_polls.push_back(p);
      polls_queued++;
   endtask

   // wait until every queued item has come back, then let the pipe settle
   task automatic wait_for_results();
      while (results_seen < polls_queued) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // APB write then read-back of one register; shadow copy updated at the write
   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      logic [31:0] readback;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({idx, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      case (idx)
         CSR_TOLERANCE: tol_cfg  = TOL_W'(value);
         CSR_HOLDOVER:  hold_cfg = HOLD_W'(value);
         default:       tmo_cfg  = TMO_W'(value);
      endcase
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      check_field("csr readback", value, readback);
   endtask

   // ---------------------------------------------------------------------
   // Sequence: reset, directed polls on the reset defaults, then random
   // phases each behind a fresh register setting with the block idle.
   // ---------------------------------------------------------------------
   initial begin
      logic [31:0] tol_v;
      logic [31:0] hold_v;
      logic [31:0] tmo_v;
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_radio_new         = 1'b0;
      req_radio_time        = '0;
      req_radio_date        = '0;
      req_rtc_new           = 1'b0;
      req_rtc_time          = '0;
      req_rtc_date          = '0;
      req_internal_new      = 1'b0;
      req_internal_time     = '0;
      req_internal_date     = '0;
      req_second_tick       = 1'b0;
      req_rtc_write_done    = 1'b0;
      req_internal_write_ok = 1'b0;
      rsp_stall             = 1'b0;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      world_t               = $urandom_range(0, TIME_MAX);
      world_d               = any_date();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed, tolerance 1, holdover 43200, timeout 1 ---
      // quiet poll
      add_poll(poll(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // lone tick: final never set, holds over on the blank internal value
      add_poll(poll(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      // radio at the top of both ranges against a blank RTC: RTC rewrite
      add_poll(poll(1, TIME_MAX, DATE_MAX, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // RTC write reported done
      add_poll(poll(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
      // RTC reads the radio value: synced, and with no radio this poll it takes final
      add_poll(poll(0, 0, 0, 1, TIME_MAX, DATE_MAX, 0, 0, 0, 0, 0, 0));
      // radio one second behind the RTC: inside tolerance
      add_poll(poll(1, TIME_MAX - 1, DATE_MAX, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // radio two seconds behind: just outside
      add_poll(poll(1, TIME_MAX - 2, DATE_MAX, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // same time, different date
      add_poll(poll(1, TIME_MAX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // internal far from final, write succeeds
      add_poll(poll(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1));
      // internal off again, write fails
      add_poll(poll(0, 0, 0, 0, 0, 0, 1, 12345, DATE_MAX, 0, 0, 0));
      // internal matching final: nothing to do, ok ignored
      add_poll(poll(0, 0, 0, 0, 0, 0, 1, TIME_MAX, 0, 0, 0, 1));
      // write done and RTC reading with no radio: RTC takes final
      add_poll(poll(0, 0, 0, 1, 43200, DATE_MAX, 0, 0, 0, 0, 1, 0));
      // ticks until RTC and final time out
      repeat (3) add_poll(poll(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      // final now held over from internal: an internal reading asks for nothing
      add_poll(poll(0, 0, 0, 0, 0, 0, 1, 100, 5, 0, 0, 1));
      // every source, tick and callback at once, all at the maxima
      add_poll(poll(1, TIME_MAX, DATE_MAX, 1, TIME_MAX, DATE_MAX, 1, TIME_MAX, DATE_MAX,
                    1, 1, 1));
      // every source at zero with tick and callback
      add_poll(poll(1, 0, 0, 1, 0, 0, 1, 0, 0, 1, 1, 0));
      // radio far off the RTC while the RTC reads in the same poll
      add_poll(poll(1, 500, 7, 1, 60000, 7, 1, 500, 7, 0, 0, 1));
      wait_for_results();

      // --- random phases ---
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin tol_v = 1;        hold_v = 43200;         tmo_v = 1;     end
            1: begin tol_v = 0;        hold_v = 0;             tmo_v = 0;     end
            2: begin tol_v = TIME_MAX; hold_v = 32'hFFFF_FFFF; tmo_v = 16'hFFFF; end
            3: begin tol_v = 3;        hold_v = 5;             tmo_v = 2;     end
            4: begin tol_v = 10;       hold_v = 2;             tmo_v = 4;     end
            5: begin tol_v = 1;        hold_v = 1;             tmo_v = 0;     end
            default: begin
               tol_v  = $urandom_range(0, 30);
               hold_v = $urandom_range(0, 10);
               tmo_v  = $urandom_range(0, 6);
            end
         endcase
         write_reg(CSR_TOLERANCE, tol_v);
         write_reg(CSR_HOLDOVER, hold_v);
         write_reg(CSR_TIMEOUT, tmo_v);
         settings_used++;
         repeat (PHASE_POLLS) add_poll(make_poll());
         wait_for_results();
      end

      repeat (4) @(posedge clock);
      if (expected_sel.size() != 0) begin
         $display("%0t ns: %0d expected results never arrived", $time, expected_sel.size());
         errors++;
      end

      $display("Checked %0d poll results across %0d register settings, long hold-off %s.",
               results_seen, settings_used, hold_done ? "done" : "missed");
      $display("Seen: %0d RTC rewrites, %0d internal rewrites; %s %0d, RTC %0d, internal %0d.",
               rtc_req_seen, int_req_seen, "final from radio", src_seen[SRC_RADIO],
               src_seen[SRC_RTC], src_seen[SRC_INT]);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/css_pkg.sv
hdl/css_core.sv
hdl/clock_source_selector_unit.sv
hdl/css_checker.sv
tb/sv/tb_top.sv
